// ===== src/slsr_pkg.sv =====
`timescale 1ns / 1ps
package slsr_pkg;

  localparam int SCAN_SLOTS    = 64;
  localparam int QUEUE_DEPTH   = 16;
  localparam int KEY_MAP_BYTES = 4;
  localparam int KEY_BYTES_RAW = ((SCAN_SLOTS / 2) + 7) / 8;
  localparam int KEY_BYTES     = (KEY_BYTES_RAW > KEY_MAP_BYTES) ? KEY_MAP_BYTES : KEY_BYTES_RAW;
  localparam int PTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int BEAT_W        = $clog2(KEY_BYTES + 2);
  localparam int ENTRY_W       = 24;

  // link command codes
  localparam logic [7:0] CMD_IDLE      = 8'h9F;
  localparam logic [7:0] CMD_TASK_HB   = 8'h91;
  localparam logic [7:0] CMD_TASK_SCAN = 8'h92;
  localparam logic [7:0] CMD_TASK_RGB  = 8'h93;
  localparam logic [7:0] CMD_TASK_OLED = 8'h94;
  localparam logic [7:0] CMD_KEY_REQ   = 8'h40;
  localparam logic [7:0] CMD_KEY_RESP  = 8'h41;
  localparam logic [7:0] CMD_SLOT      = 8'hC0;
  localparam logic [7:0] CMD_PARAM     = 8'hC1;
  localparam logic [7:0] CMD_ACK       = 8'hF0;
  localparam logic [7:0] CMD_NACK      = 8'hF1;

  typedef enum logic [1:0] {
    OP_FRAME     = 2'd0,
    OP_TAKE      = 2'd1,
    OP_CONSUME   = 2'd2,
    OP_KEY_WRITE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0,
    KIND_SLOT  = 2'd1,
    KIND_PARAM = 2'd2,
    KIND_TASK  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    JOB_REPLY  = 2'd0,
    JOB_KEYS   = 2'd1,
    JOB_REPORT = 2'd2,
    JOB_TASK   = 2'd3
  } job_kind_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] frame_len;
    logic [7:0] cmd_byte;
    logic [7:0] arg_first;
    logic [7:0] arg_second;
    logic [1:0] key_byte_index;
    logic [7:0] key_byte_value;
  } req_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] reply_byte;
    logic       reply_last;
    logic [7:0] slot_index;
    logic       slot_down;
    logic [7:0] param_index;
    logic [7:0] param_value;
    logic [2:0] task_code;
  } rsp_t;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] push_data;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    job_kind_t                     kind;
    logic [7:0]                    reply;
    logic [2:0]                    task_code;
    logic [KEY_MAP_BYTES-1:0][7:0] keys;
  } job_t;

endpackage

// ===== src/split_link_slave_responder_core.sv =====
`timescale 1ns / 1ps
// Slave-side responder for a split-keyboard link. Each request transfer is one event: a received
// frame, a take-task, a consume or a local key byte write. Events with at most one result are
// taken one per cycle while not stalled, and the next event is accepted while the previous
// result still waits in the output register. A key-state request yields a header plus 4 key
// bytes, so it holds the result path until its last byte is out; this single result register,
// fed one result per cycle while not stalled, sets the rate. Slot and parameter frames are
// queued in a 16-entry single-port-read RAM with a registered read; the popped entry is read at
// the consume transfer and then reported. No clearing pass is needed after reset.
module split_link_slave_responder_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  slsr_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output slsr_pkg::rsp_t rsp
);

  logic                                  take;
  logic                                  accept;
  logic [2:0]                            pending_task;
  logic                                  received_flag;
  logic [slsr_pkg::KEY_MAP_BYTES-1:0][7:0] key_map;
  slsr_pkg::q_ctl_t                      q_ctl;
  slsr_pkg::q_stat_t                     q_stat;
  logic [slsr_pkg::ENTRY_W-1:0]          rd_data;
  slsr_pkg::job_t                        job_in;
  logic                                  job_load;
  logic [2:0]                            pending_task_next;
  logic                                  received_flag_next;
  logic                                  is_task_cmd;

  // no transfer is taken while in reset
  assign req_stall = rst || !take;
  assign accept    = req_valid && !req_stall;

  assign is_task_cmd = (req.cmd_byte == slsr_pkg::CMD_TASK_HB)
                    || (req.cmd_byte == slsr_pkg::CMD_TASK_SCAN)
                    || (req.cmd_byte == slsr_pkg::CMD_TASK_RGB)
                    || (req.cmd_byte == slsr_pkg::CMD_TASK_OLED);

  always_comb begin
    job_in             = '0;
    job_in.kind        = slsr_pkg::JOB_REPLY;
    job_in.keys        = key_map;
    job_load           = 1'b0;
    q_ctl              = '0;
    q_ctl.push_data    = {req.arg_second, req.arg_first, req.cmd_byte};
    pending_task_next  = pending_task;
    received_flag_next = received_flag;
    if (accept) begin
      unique case (slsr_pkg::op_t'(req.opcode))
        slsr_pkg::OP_FRAME: begin
          if (req.frame_len != '0) begin
            priority if (req.cmd_byte == slsr_pkg::CMD_IDLE) begin
              job_load     = 1'b1;
              job_in.reply = (pending_task != '0) ? slsr_pkg::CMD_NACK : slsr_pkg::CMD_ACK;
            end else if (is_task_cmd) begin
              job_load          = 1'b1;
              job_in.reply      = slsr_pkg::CMD_ACK;
              pending_task_next = 3'(req.cmd_byte - slsr_pkg::CMD_TASK_HB + 8'd1);
            end else if (req.cmd_byte == slsr_pkg::CMD_KEY_REQ) begin
              job_load    = 1'b1;
              job_in.kind = slsr_pkg::JOB_KEYS;
            end else if (req.cmd_byte == slsr_pkg::CMD_SLOT
                      || req.cmd_byte == slsr_pkg::CMD_PARAM) begin
              job_load           = 1'b1;
              job_in.reply       = slsr_pkg::CMD_ACK;
              q_ctl.push         = 1'b1;
              received_flag_next = 1'b1;
            end else begin
              job_load = 1'b0;
            end
          end
        end
        slsr_pkg::OP_TAKE: begin
          job_load          = 1'b1;
          job_in.kind       = slsr_pkg::JOB_TASK;
          job_in.task_code  = pending_task;
          pending_task_next = '0;
        end
        slsr_pkg::OP_CONSUME: begin
          if (received_flag) begin
            received_flag_next = 1'b0;
            if (!q_stat.empty) begin
              q_ctl.pop   = 1'b1;
              job_load    = 1'b1;
              job_in.kind = slsr_pkg::JOB_REPORT;
            end
          end
        end
        slsr_pkg::OP_KEY_WRITE: job_load = 1'b0;
        default: job_load = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_task  <= '0;
      received_flag <= 1'b0;
      key_map       <= '0;
    end else begin
      pending_task  <= pending_task_next;
      received_flag <= received_flag_next;
      if (accept && slsr_pkg::op_t'(req.opcode) == slsr_pkg::OP_KEY_WRITE) begin
        key_map[req.key_byte_index] <= req.key_byte_value;
      end
    end
  end

  slsr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctl     (q_ctl),
    .stat    (q_stat),
    .rd_data (rd_data)
  );

  slsr_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .job_load  (job_load),
    .job_in    (job_in),
    .rd_data   (rd_data),
    .take      (take),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== src/slsr_queue.sv =====
`timescale 1ns / 1ps
module slsr_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  slsr_pkg::q_ctl_t            ctl,
  output slsr_pkg::q_stat_t           stat,
  output logic [slsr_pkg::ENTRY_W-1:0] rd_data
);

  logic [slsr_pkg::ENTRY_W-1:0] mem [slsr_pkg::QUEUE_DEPTH];
  logic [slsr_pkg::PTR_W-1:0]   wr_ptr;
  logic [slsr_pkg::PTR_W-1:0]   rd_ptr;
  logic [slsr_pkg::FILL_W-1:0]  fill;
  logic                         do_push;
  logic                         do_pop;

  function automatic logic [slsr_pkg::PTR_W-1:0] ptr_inc(input logic [slsr_pkg::PTR_W-1:0] p);
    logic [slsr_pkg::PTR_W-1:0] r;
    if (p == slsr_pkg::PTR_W'(slsr_pkg::QUEUE_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  assign stat.full  = (fill == slsr_pkg::FILL_W'(slsr_pkg::QUEUE_DEPTH));
  assign stat.empty = (fill == '0);
  // a full queue drops the entry
  assign do_push    = ctl.push && !stat.full;
  assign do_pop     = ctl.pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop) rd_ptr <= ptr_inc(rd_ptr);
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // read and write never meet on one entry: an entry is only popped once pushed earlier
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= ctl.push_data;
    if (do_pop) rd_data <= mem[rd_ptr];
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= slsr_pkg::FILL_W'(slsr_pkg::QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (fill == $past(fill) - 1'b1))
    else $error("pop did not lower fill");

endmodule

// ===== src/slsr_emitter.sv =====
`timescale 1ns / 1ps
module slsr_emitter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         job_load,
  input  slsr_pkg::job_t               job_in,
  input  logic [slsr_pkg::ENTRY_W-1:0] rd_data,
  output logic                         take,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output slsr_pkg::rsp_t               rsp
);

  logic                        job_valid;
  slsr_pkg::job_t              job;
  logic [slsr_pkg::BEAT_W-1:0] beat;
  slsr_pkg::rsp_t              cur;
  logic                        cur_last;
  logic                        move;
  logic                        done;
  logic [1:0]                  key_sel;
  logic [7:0]                  q_cmd;

  assign key_sel = 2'(beat - slsr_pkg::BEAT_W'(1));
  assign q_cmd   = rd_data[7:0];

  always_comb begin
    cur      = '0;
    cur_last = 1'b1;
    unique case (job.kind)
      slsr_pkg::JOB_REPLY: begin
        cur.result_kind = slsr_pkg::KIND_REPLY;
        cur.reply_byte  = job.reply;
        cur.reply_last  = 1'b1;
      end
      slsr_pkg::JOB_KEYS: begin
        cur.result_kind = slsr_pkg::KIND_REPLY;
        cur_last        = (beat == slsr_pkg::BEAT_W'(slsr_pkg::KEY_BYTES));
        cur.reply_last  = cur_last;
        if (beat == '0) cur.reply_byte = slsr_pkg::CMD_KEY_RESP;
        else cur.reply_byte = job.keys[key_sel];
      end
      slsr_pkg::JOB_REPORT: begin
        if (q_cmd == slsr_pkg::CMD_SLOT) begin
          cur.result_kind = slsr_pkg::KIND_SLOT;
          cur.slot_index  = rd_data[15:8];
          cur.slot_down   = |rd_data[23:16];
        end else begin
          cur.result_kind = slsr_pkg::KIND_PARAM;
          cur.param_index = rd_data[15:8];
          cur.param_value = rd_data[23:16];
        end
      end
      slsr_pkg::JOB_TASK: begin
        cur.result_kind = slsr_pkg::KIND_TASK;
        cur.task_code   = job.task_code;
      end
      default: cur = '0;
    endcase
  end

  assign move = job_valid && (!rsp_valid || !rsp_stall);
  assign done = move && cur_last;
  assign take = !job_valid || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      rsp_valid <= 1'b0;
      beat      <= '0;
    end else begin
      if (take) job_valid <= job_load;
      if (take) beat <= '0;
      else if (move) beat <= beat + 1'b1;
      if (move) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) job <= job_in;
    if (move) rsp <= cur;
  end

  a_beat_bound: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (beat <= slsr_pkg::BEAT_W'(slsr_pkg::KEY_BYTES)))
    else $error("key beat past last byte");

  a_report_cmd: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job.kind == slsr_pkg::JOB_REPORT) |->
      (q_cmd == slsr_pkg::CMD_SLOT || q_cmd == slsr_pkg::CMD_PARAM))
    else $error("queued entry carries an unknown command");

endmodule
